// ===== rtl/core/dfsm_pkg.sv =====
// Package for the distance fade state machine: field widths, payload structs,
// register indexes and fade level constants. No dependencies.
`timescale 1ns / 1ps

package dfsm_pkg;

  localparam int FADE_LEVELS = 18;
  localparam int DIST_W      = 32;
  localparam int TIME_W      = 64;
  localparam int FADE_W      = 16;
  localparam int LEVEL_W     = 5;
  localparam int PHASE_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int MS_TO_US        = 1000;
  localparam int FADE_TIME_RESET = 500;

  // Step period = fade_ms * 1000 / FADE_LEVELS, done as fade_ms * STEP_MULT >> STEP_SHIFT.
  // STEP_SHIFT keeps fade_ms * error below 2^STEP_SHIFT, so the quotient is exact.
  localparam int STEP_SHIFT  = 24;
  localparam int STEP_MULT_W = 34;
  localparam longint unsigned STEP_MULT =
    ((longint'(MS_TO_US) << STEP_SHIFT) + longint'(FADE_LEVELS) - 1) / longint'(FADE_LEVELS);
  localparam int STEP_W  = 26;
  localparam int PROD_W  = FADE_W + STEP_MULT_W;
  localparam longint unsigned STEP_RESET =
    (longint'(FADE_TIME_RESET) * longint'(MS_TO_US)) / longint'(FADE_LEVELS);

  localparam logic [LEVEL_W-1:0] LEVEL_OUT       = '0;
  localparam logic [LEVEL_W-1:0] LEVEL_FIRST_IN  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_IN        = LEVEL_W'(FADE_LEVELS - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FIRST_OUT = LEVEL_W'(FADE_LEVELS - 2);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME_MS = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] distance_sq;
    logic [TIME_W-1:0] now_us;
  } dfsm_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] fade_level;
    logic               is_out;
  } dfsm_out_t;

endpackage

// ===== rtl/core/distance_fade_state_machine.sv =====
// Distance fade state machine: window test, fade phase and level tracking.
// An accepted item is held in the input register, then loaded into the result register
// once that is free, and out_valid rises; one item per cycle sustained while out_ready is high.
// Throughput is set by the combinational state update between input and result registers.
// Reset (rst_n low, synchronous): phase initial, level 0, deadline 0, config to defaults, valids 0.
// Depends on dfsm_pkg.
`timescale 1ns / 1ps

module distance_fade_state_machine
  import dfsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dfsm_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dfsm_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [PHASE_W-1:0] {
    PH_INITIAL  = 3'd0,
    PH_OUT      = 3'd1,
    PH_FADE_IN  = 3'd2,
    PH_IN       = 3'd3,
    PH_FADE_OUT = 3'd4
  } phase_t;

  // Configuration
  logic [DIST_W-1:0] min_dist_sq_r;
  logic [DIST_W-1:0] max_dist_sq_r;
  logic [STEP_W-1:0] step_r;
  logic [PROD_W-1:0] step_prod;

  // Pipeline
  logic      s1_valid_r;
  dfsm_in_t  s1_r;
  logic      out_valid_r;
  dfsm_out_t out_r;
  dfsm_out_t out_nxt;
  logic      out_load_ok;
  logic      s1_adv;

  // Fade state
  phase_t             phase_r, phase_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [TIME_W-1:0]  deadline_r, deadline_nxt;

  logic               in_window;
  logic               due;
  logic [TIME_W-1:0]  deadline_new;
  logic [LEVEL_W-1:0] level_up;
  logic [LEVEL_W-1:0] level_dn;

  // Step period is worked out once, when the fade time is written, so the
  // item path only sees a register.
  assign step_prod = PROD_W'(cfg_wdata[FADE_W-1:0]) * PROD_W'(STEP_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_sq_r <= '0;
      max_dist_sq_r <= '1;
      step_r        <= STEP_W'(STEP_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_DIST_SQ:  min_dist_sq_r <= cfg_wdata[DIST_W-1:0];
        CFG_MAX_DIST_SQ:  max_dist_sq_r <= cfg_wdata[DIST_W-1:0];
        CFG_FADE_TIME_MS: step_r        <= step_prod[STEP_SHIFT +: STEP_W];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken; the input
  // register advances into it, and takes a new item as it leaves.
  assign out_load_ok = !out_valid_r || out_ready;
  assign s1_adv      = s1_valid_r && out_load_ok;
  assign in_ready    = !s1_valid_r || s1_adv;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  // Window test and candidate deadline for the item in the input register.
  // An empty window (min above max) falls out naturally: no distance passes.
  assign in_window    = (s1_r.distance_sq >= min_dist_sq_r) &&
                        (s1_r.distance_sq <= max_dist_sq_r);
  assign due          = (s1_r.now_us >= deadline_r);
  assign deadline_new = s1_r.now_us + TIME_W'(step_r);  // wraps modulo 2^64
  assign level_up     = (level_r < LEVEL_IN)  ? level_r + LEVEL_W'(1) : level_r;
  assign level_dn     = (level_r > LEVEL_OUT) ? level_r - LEVEL_W'(1) : level_r;

  always_comb begin
    phase_nxt    = phase_r;
    level_nxt    = level_r;
    deadline_nxt = deadline_r;
    case (phase_r)
      PH_OUT: begin
        if (in_window) begin
          phase_nxt    = PH_FADE_IN;
          level_nxt    = LEVEL_FIRST_IN;
          deadline_nxt = deadline_new;
        end
      end
      PH_FADE_IN: begin
        if (in_window) begin
          if (due) begin
            level_nxt = level_up;
            if (level_up >= LEVEL_IN) begin
              phase_nxt = PH_IN;
            end else begin
              deadline_nxt = deadline_new;
            end
          end
        end else begin
          // reverse direction, keep the level
          phase_nxt    = PH_FADE_OUT;
          deadline_nxt = deadline_new;
        end
      end
      PH_IN: begin
        if (!in_window) begin
          phase_nxt    = PH_FADE_OUT;
          level_nxt    = LEVEL_FIRST_OUT;
          deadline_nxt = deadline_new;
        end
      end
      PH_FADE_OUT: begin
        if (!in_window) begin
          if (due) begin
            level_nxt = level_dn;
            if (level_dn == LEVEL_OUT) begin
              phase_nxt = PH_OUT;
            end else begin
              deadline_nxt = deadline_new;
            end
          end
        end else begin
          phase_nxt    = PH_FADE_IN;
          deadline_nxt = deadline_new;
        end
      end
      default: begin
        // initial phase: snap straight to fully in or fully out
        if (in_window) begin
          phase_nxt = PH_IN;
          level_nxt = LEVEL_IN;
        end else begin
          phase_nxt = PH_OUT;
          level_nxt = LEVEL_OUT;
        end
      end
    endcase
  end

  always_comb begin
    out_nxt.phase      = phase_nxt;
    out_nxt.fade_level = level_nxt;
    out_nxt.is_out     = (phase_nxt == PH_OUT);
  end

  // State and registered outputs: advance only when the item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_INITIAL;
      level_r     <= LEVEL_OUT;
      deadline_r  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_load_ok) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        phase_r    <= phase_nxt;
        level_r    <= level_nxt;
        deadline_r <= deadline_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_IN)
    else $error("fade level above fully in");

  a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OUT) |-> (level_r == LEVEL_OUT))
    else $error("out phase with nonzero level");

  a_in_level: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IN) |-> (level_r == LEVEL_IN))
    else $error("in phase without full level");

  a_is_out_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_out == (out_r.phase == PH_OUT)))
    else $error("is_out flag disagrees with phase");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && (out_r.phase == phase_r) && (out_r.fade_level == level_r)))
    else $error("result register does not match updated state");
`endif

endmodule
